@@ sv/wsad_pkg.sv @@
// Shared constants and controller/datapath handshake types for the
// windowed sound alarm detector. No dependencies.
`default_nettype none

package wsad_pkg;

	// Window depth and derived widths
	localparam int WINDOW  = 40;
	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int LEVEL_W = 8;
	localparam int TIME_W  = 32;
	localparam int SUM_W   = $clog2(WINDOW * 255 + 1);
	localparam int MTHR_W  = 8;
	localparam int PTHR_W  = 8;
	localparam int IVL_W   = 16;

	// Stream word widths
	localparam int IN_W  = 40;
	localparam int OUT_W = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

	// Reset values of the configuration registers
	localparam logic [MTHR_W-1:0] MEAN_THR_RST = 8'd20;
	localparam logic [PTHR_W-1:0] PEAK_THR_RST = 8'd40;
	localparam logic [IVL_W-1:0]  INTERVAL_RST = 16'd50;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;  // capture the input word
		logic check;    // evaluate elapsed time, clear scan state
		logic rd_slot;  // read the entry at the write slot
		logic update;   // store sample, update sum, slot and time
		logic scan_rd;  // read next entry for the peak scan
		logic finish;   // load the output register
	} wsad_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic take;      // elapsed time exceeds the interval
		logic scan_last; // scan index is at the last entry
		logic out_busy;  // output register holds an untaken word
	} wsad_sts_t;

endpackage

`default_nettype wire

@@ sv/wsad_ctrl.sv @@
// Sequencing state machine of the windowed sound alarm detector.
// Depends on wsad_pkg for the command and status structs.
`default_nettype none

module wsad_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wsad_pkg::wsad_sts_t sts,
	output wsad_pkg::wsad_cmd_t cmd
);
	import wsad_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_UPDATE = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.take) begin
					cmd.rd_slot = 1'b1;
					state_d     = S_UPDATE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/wsad_dp.sv @@
// Datapath of the windowed sound alarm detector: sample ring memory,
// running sum, write slot, peak scan and output register. Uses wsad_pkg.
`default_nettype none

module wsad_dp (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  [wsad_pkg::IN_W-1:0]          in_data,
	input  wire  [wsad_pkg::MTHR_W-1:0]        mean_thr,
	input  wire  [wsad_pkg::PTHR_W-1:0]        peak_thr,
	input  wire  [wsad_pkg::IVL_W-1:0]         interval,
	input  wsad_pkg::wsad_cmd_t                cmd,
	output wsad_pkg::wsad_sts_t                sts,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [wsad_pkg::OUT_W-1:0]         out_data
);
	import wsad_pkg::*;

	logic [LEVEL_W-1:0] mem [WINDOW];
	logic [WINDOW-1:0]  valid_q;

	logic [TIME_W-1:0]  time_q;
	logic [LEVEL_W-1:0] level_q;
	logic [TIME_W-1:0]  last_time_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  scan_idx_q;
	logic [LEVEL_W-1:0] peak_q;
	logic               take_q;
	logic [LEVEL_W-1:0] rd_data_q;
	logic               rd_valid_q;
	logic               scan_pend_s1;
	logic               out_vld_q;
	logic [OUT_W-1:0]   out_data_q;

	logic [TIME_W-1:0]  elapsed;
	logic               take;
	logic [SLOT_W-1:0]  rd_addr;
	logic               rd_en;
	logic [LEVEL_W-1:0] rd_eff;
	logic [SLOT_W-1:0]  slot_next;
	logic [SUM_W-1:0]   mean_lim;
	logic               alarm;

	// Elapsed time since the last stored sample, modulo 2^32
	assign elapsed = time_q - last_time_q;
	assign take    = elapsed > {{(TIME_W-IVL_W){1'b0}}, interval};

	assign rd_en   = cmd.rd_slot | cmd.scan_rd;
	assign rd_addr = cmd.scan_rd ? scan_idx_q : slot_q;
	assign rd_eff  = rd_valid_q ? rd_data_q : '0;

	assign slot_next = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

	assign mean_lim = SUM_W'(mean_thr) * SUM_W'(WINDOW);
	assign alarm    = (sum_q > mean_lim) && (peak_q > peak_thr);

	assign sts.take      = take;
	assign sts.scan_last = (scan_idx_q == SLOT_W'(WINDOW - 1));
	assign sts.out_busy  = out_vld_q & ~out_ready;

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

	// Ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem[slot_q] <= level_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Entry valid bits: an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				valid_q[slot_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// Capture the input word and the store decision
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			time_q  <= in_data[TIME_W-1:0];
			level_q <= in_data[TIME_W +: LEVEL_W];
		end
		if (cmd.check) begin
			take_q <= take;
		end
	end

	// Window state: sum, write slot, time of last store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			slot_q      <= '0;
			last_time_q <= '0;
		end else if (cmd.update) begin
			sum_q       <= sum_q - SUM_W'(rd_eff) + SUM_W'(level_q);
			slot_q      <= slot_next;
			last_time_q <= time_q;
		end
	end

	// Peak scan: issue one read a cycle, compare its data in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_pend_s1 <= 1'b0;
		end else begin
			scan_pend_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			scan_idx_q <= '0;
			peak_q     <= '0;
		end else begin
			if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (scan_pend_s1 && (rd_eff > peak_q)) begin
				peak_q <= rd_eff;
			end
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finish) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= {{(OUT_W-2-LEVEL_W){1'b0}}, peak_q, take_q, alarm};
		end
	end

endmodule

`default_nettype wire

@@ sv/windowed_sound_alarm_detector.sv @@
// Top level of the windowed sound alarm detector: configuration registers,
// controller and datapath. Depends on wsad_pkg, wsad_ctrl and wsad_dp.
//
// Channel   Direction  Handshake                    Word
// s_axis    in         s_axis_tvalid/s_axis_tready  time_ms[31:0], sound_level[39:32]
// m_axis    out        m_axis_tvalid/m_axis_tready  alarm[0], sample_taken[1], window_peak[9:2]
// cfg       in         cfg_valid/cfg_ready          cfg_index: register, cfg_data: value
//
// One word at a time: each word passes CHECK, UPDATE (only when the sample
// is stored), a serial peak scan over the single read port of the sample
// ring, DRAIN and DONE before the next word is taken.
// Reset clears the sum, slot, time and the per-entry valid bits at once.
// A waiting result stalls only the final step; the next word is taken as
// soon as the result has moved to the output register.
`default_nettype none

module windowed_sound_alarm_detector (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [31:0] time_ms, [39:32] sound_level
	input  wire  [wsad_pkg::IN_W-1:0]             s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// [0] alarm, [1] sample_taken, [9:2] window_peak, [15:10] zero
	output logic [wsad_pkg::OUT_W-1:0]            m_axis_tdata,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [wsad_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [wsad_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import wsad_pkg::*;

	logic [MTHR_W-1:0] mean_thr_q;
	logic [PTHR_W-1:0] peak_thr_q;
	logic [IVL_W-1:0]  interval_q;
	wsad_cmd_t         cmd;
	wsad_sts_t         sts;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_thr_q <= MEAN_THR_RST;
			peak_thr_q <= PEAK_THR_RST;
			interval_q <= INTERVAL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MEAN_THR: mean_thr_q <= cfg_data[MTHR_W-1:0];
				REG_PEAK_THR: peak_thr_q <= cfg_data[PTHR_W-1:0];
				REG_INTERVAL: interval_q <= cfg_data[IVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wsad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wsad_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.mean_thr  (mean_thr_q),
		.peak_thr  (peak_thr_q),
		.interval  (interval_q),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// One word in flight: no second accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a word is in progress");

	// A new result appears only as the controller returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result raised while controller busy");

	// An alarm needs a nonzero peak
	a_alarm_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[9:2] != '0))
		else $error("alarm with zero window peak");

endmodule

`default_nettype wire

@@ test/windowed_sound_alarm_detector_tb.sv @@
// Testbench for windowed_sound_alarm_detector: drives sample words, predicts each
// alarm word from its own window model and compares every field.
// Depends on wsad_pkg and the detector RTL.

module windowed_sound_alarm_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wsad_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3; // no register behind it
	localparam int SETTLE_CYCLES = 60;  // a little over one word through the scan
	localparam int HOLD_CYCLES   = 600; // long enough to back the block up

	// Result word, alarm in bit 0
	typedef struct packed {
		logic [5:0]         pad;
		logic [LEVEL_W-1:0] peak;
		logic               taken;
		logic               alarm;
	} alarm_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Window model
	logic [MTHR_W-1:0]  mean_thr;
	logic [PTHR_W-1:0]  peak_thr;
	logic [IVL_W-1:0]   interval_ms;
	logic [LEVEL_W-1:0] level_ring [WINDOW];
	int unsigned        ring_slot;
	int unsigned        ring_sum;
	logic [TIME_W-1:0]  last_store_ms;

	alarm_word_t alarm_words_due [$];
	int          mismatch_count = 0;
	logic [TIME_W-1:0] clock_ms;
	bit          gaps_on = 1'b1;
	bit          hold_req = 1'b0;
	bit          word_offered = 1'b0;
	int          sender_gap = 0;

	windowed_sound_alarm_detector dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("** windowed_sound_alarm_detector: FAILED **");
		$finish;
	end

	// Clear the model to its power-up state
	function automatic void reset_window_model();
		mean_thr      = MEAN_THR_RST;
		peak_thr      = PEAK_THR_RST;
		interval_ms   = INTERVAL_RST;
		ring_slot     = 0;
		ring_sum      = 0;
		last_store_ms = '0;
		foreach (level_ring[i]) level_ring[i] = '0;
	endfunction

	// Mirror one register write; unknown indexes drop out
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_MEAN_THR: mean_thr = val[MTHR_W-1:0];
			REG_PEAK_THR: peak_thr = val[PTHR_W-1:0];
			REG_INTERVAL: interval_ms = val[IVL_W-1:0];
			default: ;
		endcase
	endfunction

	// Store the sample if the interval has passed, then judge mean and peak
	function automatic alarm_word_t predict_alarm_word(input logic [TIME_W-1:0] now,
			input logic [LEVEL_W-1:0] lvl);
		alarm_word_t       w;
		logic [TIME_W-1:0] elapsed;
		logic [LEVEL_W-1:0] top;
		w = '0;
		elapsed = now - last_store_ms;
		if (elapsed > TIME_W'(interval_ms)) begin
			ring_sum = ring_sum - level_ring[ring_slot] + lvl;
			level_ring[ring_slot] = lvl;
			last_store_ms = now;
			ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
			w.taken = 1'b1;
		end
		top = '0;
		foreach (level_ring[i]) if (level_ring[i] > top) top = level_ring[i];
		w.peak  = top;
		w.alarm = (ring_sum > int'(mean_thr) * WINDOW) && (top > peak_thr);
		return w;
	endfunction

	// Next timer value: mostly near the interval, some repeats, steps back and jumps
	function automatic logic [TIME_W-1:0] next_time();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			clock_ms = clock_ms + $urandom_range(0, 2 * int'(interval_ms) + 2);
		else if (pick < 80)
			clock_ms = clock_ms + interval_ms + $urandom_range(0, 1);
		else if (pick < 88)
			clock_ms = clock_ms;
		else if (pick < 94)
			clock_ms = clock_ms - $urandom_range(1, 5000);
		else
			clock_ms = $urandom();
		return clock_ms;
	endfunction

	// Offer one sample word; keep valid up if the next word follows at once
	task automatic send_sample(input logic [TIME_W-1:0] now, input logic [LEVEL_W-1:0] lvl);
		repeat (sender_gap) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {lvl, now};
		do @(posedge clk); while (!s_axis_tready);
		alarm_words_due.push_back(predict_alarm_word(now, lvl));
		sender_gap = gaps_on ? $urandom_range(0, 7) : 0;
		word_offered = (sender_gap == 0);
		if (sender_gap != 0) s_axis_tvalid <= 1'b0;
	endtask

	// Drop valid, wait for every result, then let the block go quiet
	task automatic settle_block();
		if (word_offered) begin
			s_axis_tvalid <= 1'b0;
			word_offered = 1'b0;
		end
		while (alarm_words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		if (last) cfg_valid <= 1'b0;
	endtask

	task automatic set_thresholds(input logic [CFG_DATA_W-1:0] mean_val,
			input logic [CFG_DATA_W-1:0] peak_val, input logic [CFG_DATA_W-1:0] ivl_val);
		settle_block();
		write_reg(REG_MEAN_THR, mean_val, 1'b0);
		write_reg(REG_PEAK_THR, peak_val, 1'b0);
		write_reg(REG_INTERVAL, ivl_val, 1'b1);
	endtask

	// Default thresholds from power-up: first store, interval edge, wrap, step back
	task automatic test_power_up_window();
		gaps_on = 1'b1;
		send_sample(32'd0, 8'd200);
		send_sample(32'd50, 8'd200);
		send_sample(32'd51, 8'd255);
		send_sample(32'hFFFF_FFFF, 8'd0);
		send_sample(32'd49, 8'd77);
		send_sample(32'd50, 8'd128);
		send_sample(32'd10, 8'd255);
		send_sample(32'd120, 8'd255);
	endtask

	// Zero and full-range interval, threshold extremes, masked data, spare index
	task automatic test_edge_cases();
		settle_block();
		write_reg(REG_INTERVAL, 16'd0, 1'b0);
		write_reg(REG_SPARE, 16'hFFFF, 1'b0);
		write_reg(REG_MEAN_THR, 16'hFF00, 1'b0);
		write_reg(REG_PEAK_THR, 16'h0000, 1'b1);
		send_sample(32'd120, 8'd1);
		send_sample(32'd121, 8'd0);
		set_thresholds(16'd255, 16'd0, 16'd0);
		send_sample(32'd200, 8'd255);
		set_thresholds(16'd0, 16'd255, 16'hFFFF);
		send_sample(32'd200 + 32'd65535, 8'd9);
		send_sample(32'd200 + 32'd65536, 8'd9);
		clock_ms = 32'd200 + 32'd65536;
	endtask

	task automatic run_listening(input int count, input int lo, input int hi);
		logic [LEVEL_W-1:0] lvl;
		repeat (count) begin
			lvl = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom_range(0, 255))
				: LEVEL_W'($urandom_range(lo, hi));
			send_sample(next_time(), lvl);
		end
	endtask

	// Phases of random timing and loudness under several threshold settings
	task automatic test_random_listening();
		int lo;
		int hi;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					set_thresholds(16'd20, 16'd40, 16'd50);
					gaps_on = 1'b1; lo = 0; hi = 80;
				end
				1: begin
					set_thresholds(16'd0, 16'd0, 16'd0);
					gaps_on = 1'b0; lo = 0; hi = 10;
				end
				2: begin
					set_thresholds(16'hFFFF, 16'h00FF, 16'hFFFF);
					gaps_on = 1'b1; lo = 200; hi = 255;
				end
				default: begin
					set_thresholds({8'($urandom()), 8'($urandom_range(0, 200))},
						{8'($urandom()), 8'($urandom_range(0, 255))},
						16'($urandom_range(0, 300)));
					gaps_on = 1'($urandom_range(0, 1));
					lo = $urandom_range(0, 128);
					hi = $urandom_range(lo, 255);
				end
			endcase
			run_listening(120, lo, hi);
		end
	endtask

	// Hold the result side while samples keep coming, so the input stalls
	task automatic test_output_backpressure();
		set_thresholds(16'd30, 16'd100, 16'd20);
		gaps_on = 1'b0;
		hold_req = 1'b1;
		run_listening(30, 0, 255);
	endtask

	// Result side: random stalls per word, one long hold on request
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = gaps_on ? $urandom_range(0, 7) : 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		alarm_word_t got;
		alarm_word_t want;
		if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			got = alarm_word_t'(m_axis_tdata);
			if (alarm_words_due.size() == 0) begin
				$error("unexpected result word %h", m_axis_tdata);
				mismatch_count++;
			end else begin
				want = alarm_words_due.pop_front();
				if (got.alarm !== want.alarm) begin
					$error("alarm: expected %0d, got %0d", want.alarm, got.alarm);
					mismatch_count++;
				end
				if (got.taken !== want.taken) begin
					$error("sample_taken: expected %0d, got %0d", want.taken, got.taken);
					mismatch_count++;
				end
				if (got.peak !== want.peak) begin
					$error("window_peak: expected %0d, got %0d", want.peak, got.peak);
					mismatch_count++;
				end
				if (got.pad !== want.pad) begin
					$error("pad: expected %0h, got %0h", want.pad, got.pad);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		clock_ms      = '0;
		reset_window_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_window();
		test_edge_cases();
		test_random_listening();
		test_output_backpressure();
		settle_block();

		if (mismatch_count == 0 && alarm_words_due.size() == 0) begin
			$display("** windowed_sound_alarm_detector: PASSED **");
		end else begin
			$display("** windowed_sound_alarm_detector: FAILED **");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/wsad_pkg.sv
sv/wsad_ctrl.sv
sv/wsad_dp.sv
sv/windowed_sound_alarm_detector.sv
test/windowed_sound_alarm_detector_tb.sv
